// ----- hdl/pcq_pkg.sv -----
// package for the priority class queue: codes, sizes and shared types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package pcq_pkg;
  localparam int NumCat     = 4;
  localparam int QueueDepth = 32;
  localparam int CatW       = 2;
  localparam int PtrW       = 5;
  localparam int CntW       = 6;
  localparam int EntryW     = 33;
  localparam int EntryAw    = CatW + PtrW;
  localparam int CtrAw      = 6;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_STAT = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ENQUEUED = 3'd0,
    ST_DISABLED = 3'd1,
    ST_TOO_BIG  = 3'd2,
    ST_DEQUEUED = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_HEAD_DROP = 3'd5,
    ST_STAT     = 3'd6
  } status_t;

  localparam logic [1:0] KIND_ENQ  = 2'd0;
  localparam logic [1:0] KIND_DEQ  = 2'd1;
  localparam logic [1:0] KIND_OVF  = 2'd2;
  localparam logic [1:0] KIND_BIG  = 2'd3;
  localparam logic [2:0] KIND_HWM  = 3'd4;
  localparam logic [2:0] KIND_HWL  = 3'd5;

  localparam logic [2:0] REG_ACTIVE = 3'd0;
  localparam logic [2:0] REG_LIM0   = 3'd1;
  localparam logic [2:0] REG_LIM3   = 3'd4;
  localparam logic [2:0] REG_MAXLEN = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_CTR_RD,
    S_CTR_WR,
    S_EMIT,
    S_WAIT
  } state_t;

  // counter update request toward the counter memory
  typedef struct packed {
    logic             req;
    logic [CtrAw-1:0] addr;
    logic [15:0]      len;
  } ctr_req_t;

  function automatic logic [CntW-1:0] ptr_next(input logic [PtrW-1:0] p);
    logic [CntW-1:0] q;
    q = {1'b0, p} + 1'b1;
    return (q >= CntW'(QueueDepth)) ? '0 : q;
  endfunction
endpackage
`default_nettype wire

// ----- hdl/pcq_ctr_mem.sv -----
// traffic counter memory: one read-modify-write of packet and byte counters
// depends on pcq_pkg
`timescale 1ns / 1ps
`default_nettype none
module pcq_ctr_mem (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire pcq_pkg::ctr_req_t         upd,
  input  wire logic [pcq_pkg::CtrAw-1:0] rd_addr,
  input  wire logic                      rd_en,
  output logic      [63:0]               rd_data,
  output logic                           busy
);
  logic [63:0] pkt_mem [0:31];
  logic [63:0] byt_mem [0:31];
  logic [31:0] vld_r;
  logic [63:0] pkt_q_r, byt_q_r;
  logic        phase_r;
  logic [pcq_pkg::CtrAw-2:0] row_r;
  logic [15:0] len_r;
  logic        sel_r;

  wire [pcq_pkg::CtrAw-2:0] rrow = upd.req ? upd.addr[pcq_pkg::CtrAw-1:1]
                                           : rd_addr[pcq_pkg::CtrAw-1:1];
  assign busy = phase_r;

  // read port, registered, and write-back of an update
  always_ff @(posedge clk) begin
    if (upd.req || rd_en) begin
      pkt_q_r <= pkt_mem[rrow];
      byt_q_r <= byt_mem[rrow];
      row_r   <= rrow;
      sel_r   <= rd_addr[0];
    end
    if (upd.req) len_r <= upd.len;
    if (phase_r) begin
      pkt_mem[row_r] <= (vld_r[row_r] ? pkt_q_r : 64'd0) + 64'd1;
      byt_mem[row_r] <= (vld_r[row_r] ? byt_q_r : 64'd0) + {48'd0, len_r};
    end
  end

  // update phase and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      vld_r   <= '0;
    end else begin
      phase_r <= upd.req;
      if (phase_r) vld_r[row_r] <= 1'b1;
    end
  end

  assign rd_data = !vld_r[row_r] ? 64'd0 : (sel_r ? byt_q_r : pkt_q_r);
endmodule
`default_nettype wire

// ----- hdl/priority_class_queue_with_drops_core.sv -----
// top level of the priority class queue: sequencer, entry memory, pointers
// depends on pcq_pkg and pcq_ctr_mem
// an item goes through the decide, counter read, counter write and emit states;
// emit holds on output stall, dropped heads repeat them, new items wait for idle
// reset: synchronous active low clears pointers, fills, marks and counters
// entry memory is not cleared; it is read only where written
`timescale 1ns / 1ps
`default_nettype none
module priority_class_queue_with_drops_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_operation,
  input  wire logic [1:0]  in_category,
  input  wire logic [15:0] in_descriptor,
  input  wire logic [15:0] in_packet_length,
  input  wire logic        in_multicast,
  input  wire logic [2:0]  in_stat_kind,
  input  wire logic        in_stat_bytes,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [1:0]       out_out_category,
  output logic [15:0]      out_out_descriptor,
  output logic [15:0]      out_out_length,
  output logic             out_out_multicast,
  output logic [63:0]      out_stat_value,
  output logic             out_last,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int CW = pcq_pkg::CatW;
  localparam int PW = pcq_pkg::PtrW;
  localparam int NW = pcq_pkg::CntW;

  function automatic logic [PW-1:0] ptr_lo(input logic [NW-1:0] v);
    return v[PW-1:0];
  endfunction

  // configuration
  logic [2:0]  act_r;
  logic [NW-1:0] lim_r [0:pcq_pkg::NumCat-1];
  logic [15:0] maxlen_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r    <= 3'd4;
      maxlen_r <= '0;
      for (int i = 0; i < pcq_pkg::NumCat; i++) lim_r[i] <= NW'(32);
    end else if (cfg_we) begin
      if (cfg_index == pcq_pkg::REG_ACTIVE) act_r <= cfg_data[2:0];
      else if (cfg_index >= pcq_pkg::REG_LIM0 && cfg_index <= pcq_pkg::REG_LIM3)
        lim_r[CW'(cfg_index - pcq_pkg::REG_LIM0)] <= cfg_data[NW-1:0];
      else if (cfg_index == pcq_pkg::REG_MAXLEN) maxlen_r <= cfg_data;
    end
  end

  // per-category bookkeeping
  logic [PW-1:0] head_r [0:pcq_pkg::NumCat-1];
  logic [PW-1:0] tail_r [0:pcq_pkg::NumCat-1];
  logic [NW-1:0] fill_r [0:pcq_pkg::NumCat-1];
  logic [NW-1:0] hwm_r  [0:pcq_pkg::NumCat-1];
  logic [NW-1:0] hwl_r  [0:pcq_pkg::NumCat-1];

  // captured item
  pcq_pkg::op_t  op_r;
  logic [CW-1:0] cat_r;
  logic [15:0]   desc_r, len_r;
  logic          mc_r, bytes_r;
  logic [2:0]    kind_r;

  pcq_pkg::state_t state_r, state_nxt;

  // output register
  logic        ov_r;
  logic [2:0]  ost_r;
  logic [1:0]  ocat_r;
  logic [15:0] odesc_r, olen_r;
  logic        omc_r, olast_r;
  logic [63:0] oval_r;

  // entry memory
  logic [pcq_pkg::EntryW-1:0] emem [0:pcq_pkg::NumCat*pcq_pkg::QueueDepth-1];
  logic [pcq_pkg::EntryW-1:0] eq_r;
  logic                        e_we, e_re;
  logic [pcq_pkg::EntryAw-1:0] e_waddr, e_raddr;

  always_ff @(posedge clk) begin
    if (e_we) emem[e_waddr] <= {mc_r, len_r, desc_r};
    if (e_re) eq_r <= emem[e_raddr];
  end

  // decision on the captured item
  logic [NW-1:0] elim;
  logic          do_head, too_big, deq_hit, enq_drop;
  logic [CW-1:0] deq_cat;
  always_comb begin
    elim   = (lim_r[cat_r] > NW'(pcq_pkg::QueueDepth)) ? NW'(pcq_pkg::QueueDepth)
                                                      : lim_r[cat_r];
    do_head = (fill_r[cat_r] >= elim) && (fill_r[cat_r] != '0);
    enq_drop = (lim_r[cat_r] != '0) && do_head;
    too_big = (maxlen_r != '0) && (len_r > maxlen_r);
    deq_hit = 1'b0;
    deq_cat = '0;
    for (int i = 0; i < pcq_pkg::NumCat; i++) begin
      if (32'(i) < 32'(act_r) && fill_r[i] != '0) begin
        deq_hit = 1'b1;
        deq_cat = CW'(i);
      end
    end
  end

  // pending emission and counter work
  logic [2:0]  pst_r;
  logic [CW-1:0] pcat_r;
  logic        pent_r, plast_r, pstat_r;
  logic [63:0] pval_r;
  logic        loop_r;

  pcq_pkg::ctr_req_t upd;
  logic        crd_en;
  logic [63:0] crd_data;
  logic        cbusy;

  pcq_ctr_mem u_ctr (
    .clk(clk), .rst_n(rst_n), .upd(upd),
    .rd_addr({cat_r, kind_r[1:0], mc_r, bytes_r}), .rd_en(crd_en),
    .rd_data(crd_data), .busy(cbusy)
  );

  wire out_free = !ov_r || !out_stall;
  assign in_stall = (state_r != pcq_pkg::S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pcq_pkg::S_IDLE:   if (in_valid && in_operation != pcq_pkg::OP_NONE)
                           state_nxt = pcq_pkg::S_DECIDE;
      pcq_pkg::S_DECIDE: state_nxt = pcq_pkg::S_CTR_RD;
      pcq_pkg::S_CTR_RD: state_nxt = pcq_pkg::S_CTR_WR;
      pcq_pkg::S_CTR_WR: state_nxt = pcq_pkg::S_EMIT;
      pcq_pkg::S_EMIT:   if (out_free)
                           state_nxt = loop_r ? pcq_pkg::S_DECIDE : pcq_pkg::S_IDLE;
      default:           state_nxt = pcq_pkg::S_IDLE;
    endcase
  end

  // decide-stage actions, plus the dequeue count in the counter-read state
  logic [CW-1:0] ucat;
  logic [1:0]    ukind;
  logic          umc, ucount;
  logic [15:0]   ulen;
  always_comb begin
    e_we = 1'b0; e_re = 1'b0;
    e_waddr = {cat_r, tail_r[cat_r]};
    e_raddr = {cat_r, head_r[cat_r]};
    ucount = 1'b0; ucat = cat_r; ukind = pcq_pkg::KIND_ENQ; umc = mc_r; ulen = len_r;
    crd_en = 1'b0;
    if (state_r == pcq_pkg::S_DECIDE) begin
      case (op_r)
        pcq_pkg::OP_ENQ: begin
          if (lim_r[cat_r] == '0) begin
            ucount = 1'b1; ukind = pcq_pkg::KIND_OVF;
          end else if (do_head) begin
            ucount = 1'b1; ukind = pcq_pkg::KIND_OVF; e_re = 1'b1;
          end else if (too_big) begin
            ucount = 1'b1; ukind = pcq_pkg::KIND_BIG;
          end else begin
            ucount = 1'b1; e_we = 1'b1;
          end
        end
        pcq_pkg::OP_DEQ: begin
          e_raddr = {deq_cat, head_r[deq_cat]};
          e_re = deq_hit;
        end
        pcq_pkg::OP_STAT: crd_en = 1'b1;
        default: ;
      endcase
    end
    // dequeue counting uses the entry read back, in the counter-read state that follows
    if (state_r == pcq_pkg::S_CTR_RD && op_r == pcq_pkg::OP_DEQ && pst_r ==
        pcq_pkg::ST_DEQUEUED) begin
      ucount = 1'b1; ucat = pcat_r; ukind = pcq_pkg::KIND_DEQ;
      umc = eq_r[32]; ulen = eq_r[31:16];
    end
    upd.req  = ucount;
    upd.addr = {ucat, ukind, umc, 1'b0};
    upd.len  = ulen;
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcq_pkg::S_IDLE;
      ov_r    <= 1'b0;
      loop_r  <= 1'b0;
      for (int i = 0; i < pcq_pkg::NumCat; i++) begin
        head_r[i] <= '0; tail_r[i] <= '0; fill_r[i] <= '0;
        hwm_r[i]  <= '0; hwl_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      // result valid: set on emission, cleared when taken
      if (state_r == pcq_pkg::S_EMIT && out_free) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
      case (state_r)
        pcq_pkg::S_IDLE: if (in_valid) begin
          op_r <= pcq_pkg::op_t'(in_operation);
          cat_r <= in_category; desc_r <= in_descriptor;
          len_r <= in_packet_length; mc_r <= in_multicast;
          kind_r <= in_stat_kind; bytes_r <= in_stat_bytes;
        end
        pcq_pkg::S_DECIDE: begin
          case (op_r)
            pcq_pkg::OP_ENQ: begin
              pcat_r <= cat_r; pstat_r <= 1'b0; pval_r <= '0;
              pent_r <= enq_drop; plast_r <= !enq_drop; loop_r <= enq_drop;
              if (lim_r[cat_r] == '0) pst_r <= pcq_pkg::ST_DISABLED;
              else if (do_head) begin
                pst_r <= pcq_pkg::ST_HEAD_DROP;
                head_r[cat_r] <= ptr_lo(pcq_pkg::ptr_next(head_r[cat_r]));
                fill_r[cat_r] <= fill_r[cat_r] - NW'(1);
              end else if (too_big) pst_r <= pcq_pkg::ST_TOO_BIG;
              else begin
                pst_r <= pcq_pkg::ST_ENQUEUED;
                tail_r[cat_r] <= ptr_lo(pcq_pkg::ptr_next(tail_r[cat_r]));
                fill_r[cat_r] <= fill_r[cat_r] + NW'(1);
                if (fill_r[cat_r] + NW'(1) > hwm_r[cat_r]) begin
                  hwm_r[cat_r] <= fill_r[cat_r] + NW'(1);
                  hwl_r[cat_r] <= lim_r[cat_r];
                end
              end
            end
            pcq_pkg::OP_DEQ: begin
              pstat_r <= 1'b0; pval_r <= '0; loop_r <= 1'b0; plast_r <= 1'b1;
              pent_r <= deq_hit;
              if (deq_hit) begin
                pst_r <= pcq_pkg::ST_DEQUEUED; pcat_r <= deq_cat;
                head_r[deq_cat] <= ptr_lo(pcq_pkg::ptr_next(head_r[deq_cat]));
                fill_r[deq_cat] <= fill_r[deq_cat] - NW'(1);
              end else begin
                pst_r <= pcq_pkg::ST_EMPTY; pcat_r <= '0;
              end
            end
            default: begin
              pst_r <= pcq_pkg::ST_STAT; pcat_r <= cat_r;
              pent_r <= 1'b0; loop_r <= 1'b0; plast_r <= 1'b1;
              pstat_r <= (kind_r[2] == 1'b0);
              if (kind_r == pcq_pkg::KIND_HWM) pval_r <= 64'(hwm_r[cat_r]);
              else if (kind_r == pcq_pkg::KIND_HWL) pval_r <= 64'(hwl_r[cat_r]);
              else pval_r <= '0;
            end
          endcase
        end
        pcq_pkg::S_EMIT: if (out_free) begin
          ost_r   <= pst_r;
          ocat_r  <= pcat_r;
          odesc_r <= pent_r ? eq_r[15:0] : 16'd0;
          olen_r  <= pent_r ? eq_r[31:16] : 16'd0;
          omc_r   <= pent_r ? eq_r[32] : 1'b0;
          oval_r  <= pstat_r ? crd_data : pval_r;
          olast_r <= plast_r;
        end
        default: ;
      endcase
    end
  end

  assign out_valid          = ov_r;
  assign out_status         = ost_r;
  assign out_out_category   = ocat_r;
  assign out_out_descriptor = odesc_r;
  assign out_out_length     = olen_r;
  assign out_out_multicast  = omc_r;
  assign out_stat_value     = oval_r;
  assign out_last           = olast_r;

`ifndef SYNTHESIS
  // counter update never overlaps the second phase of a previous one
  a_ctr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    cbusy |-> !upd.req) else $error("counter update overlap");
  // a result is only produced after an item has been taken
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pcq_pkg::S_EMIT) |-> in_stall) else $error("emit while idle");
  // fill of category 0 never exceeds depth
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r[0] <= NW'(pcq_pkg::QueueDepth)) else $error("fill overrun");
`endif
endmodule
`default_nettype wire
